// File: sv/csrspmv_pkg.sv
// shared types and constants for the compressed-row sparse matrix-vector block
// depends on nothing; imported by csrspmv_mac and csr_sparse_matrix_vector_multiply
`timescale 1ns / 1ps
`default_nettype none

package csrspmv_pkg;

    localparam int unsigned Q_W     = 32;  // q16.16 word
    localparam int unsigned PROD_W  = 64;  // full q32.32 product
    localparam int unsigned ACC_W   = 48;  // accumulator, 16 fraction bits
    localparam int unsigned FRAC_W  = 16;
    localparam int unsigned ROW_W   = 16;
    localparam int unsigned IDX_W   = 10;
    localparam int unsigned LEN_W   = 11;
    localparam int unsigned CMP_W   = 17;  // wide enough for any depth in range

    localparam logic [LEN_W-1:0] LEN_RESET = 11'd1024;

    typedef enum logic {
        ACT_LOAD    = 1'b0,
        ACT_NONZERO = 1'b1
    } action_t;

    // nonzero entering the multiply, vector element arrives from the store
    typedef struct packed {
        logic                    valid;
        logic                    bad;
        logic                    last;
        logic [ROW_W-1:0]        row;
        logic signed [Q_W-1:0]   value;
    } mac_in_t;

    // finished row, sum still at accumulator width
    typedef struct packed {
        logic                    valid;
        logic                    bad;
        logic [ROW_W-1:0]        row;
        logic signed [ACC_W-1:0] sum;
    } row_rep_t;

endpackage

`default_nettype wire

// File: sv/csr_sparse_matrix_vector_multiply.sv
// top level of the compressed-row sparse matrix times dense vector block
// depends on csrspmv_pkg and csrspmv_mac
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  handshake            word
// s_        in   s_valid / s_ready    action, index, value, row, row_last
// m_        out  m_valid / m_ready    out_row, row_sum, saturated, bad_column
// cfg_      in   cfg_valid / cfg_ready vector_length (always ready)
//
// one word a cycle unless m_ready holds it; m_valid trails a row's last nonzero by each stage
// stages: vector store read, 32x32 multiply, 48-bit accumulate, q16.16 clip into output register
// the whole pipeline holds while a result waits on m_ready, so s_ready follows that
// synchronous active-low reset clears control and the accumulator; the store is not cleared

module csr_sparse_matrix_vector_multiply
    import csrspmv_pkg::*;
#(
    parameter int unsigned VEC_DEPTH = 1024
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic                  s_action,
    input  wire logic [IDX_W-1:0]      s_index,
    input  wire logic signed [Q_W-1:0] s_value,
    input  wire logic [ROW_W-1:0]      s_row,
    input  wire logic                  s_row_last,

    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [ROW_W-1:0]           m_out_row,
    output logic signed [Q_W-1:0]      m_row_sum,
    output logic                       m_saturated,
    output logic                       m_bad_column,

    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [LEN_W-1:0]      cfg_wdata
);

    localparam int unsigned          AW      = $clog2(VEC_DEPTH);
    localparam logic [CMP_W-1:0]     DEPTH_C = CMP_W'(VEC_DEPTH);

    // configuration register, to be written only while no word is in flight
    logic [LEN_W-1:0] vector_length_reg;

    // vector store, one write or one read a cycle
    logic signed [Q_W-1:0] vec_mem [VEC_DEPTH];
    logic signed [Q_W-1:0] rd_data_reg;

    logic             adv;
    logic             accept;
    logic             is_nz;
    logic [AW-1:0]    addr;
    logic [CMP_W-1:0] idx_ext;
    logic             in_store;
    logic             col_ok;

    mac_in_t          nz_reg;
    row_rep_t         rep;

    logic                  out_valid_reg;
    logic [ROW_W-1:0]      out_row_reg;
    logic signed [Q_W-1:0] out_sum_reg;
    logic                  out_sat_reg;
    logic                  out_bad_reg;

    logic                  clip_hit;
    logic signed [Q_W-1:0] clip_val;

    // advance whenever the output register is free or being drained
    assign adv     = !out_valid_reg || m_ready;
    assign s_ready = adv;
    assign accept  = s_valid && s_ready;
    assign is_nz   = (s_action == ACT_NONZERO);

    assign addr     = AW'(s_index);
    assign idx_ext  = CMP_W'(s_index);
    assign in_store = idx_ext < DEPTH_C;
    // effective length is the smaller of the register and the store depth
    assign col_ok   = in_store && (idx_ext < CMP_W'(vector_length_reg));

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vector_length_reg <= LEN_RESET;
        end else if (cfg_valid && cfg_ready) begin
            vector_length_reg <= cfg_wdata;
        end
    end

    // loads write at acceptance; a later nonzero reads after that edge, so no forwarding
    always_ff @(posedge aclk) begin
        if (accept && !is_nz && in_store) begin
            vec_mem[addr] <= s_value;
        end
        if (accept && is_nz) begin
            rd_data_reg <= vec_mem[addr];
        end
    end

    // nonzero held alongside its store read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nz_reg.valid <= 1'b0;
        end else if (adv) begin
            nz_reg.valid <= accept && is_nz;
        end
        if (accept && is_nz) begin
            nz_reg.bad   <= !col_ok;
            nz_reg.last  <= s_row_last;
            nz_reg.row   <= s_row;
            nz_reg.value <= s_value;
        end
    end

    csrspmv_mac u_mac (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .nz_in    (nz_reg),
        .vec_elem (rd_data_reg),
        .rep      (rep)
    );

    // clip to q16.16: fits when the top bits all match the sign
    always_comb begin
        clip_hit = !((&rep.sum[ACC_W-1:Q_W-1]) || !(|rep.sum[ACC_W-1:Q_W-1]));
        if (clip_hit) begin
            clip_val = rep.sum[ACC_W-1] ? {1'b1, {(Q_W-1){1'b0}}} : {1'b0, {(Q_W-1){1'b1}}};
        end else begin
            clip_val = rep.sum[Q_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= rep.valid;
        end
        if (adv) begin
            out_row_reg <= rep.row;
            out_sum_reg <= clip_val;
            out_sat_reg <= clip_hit;
            out_bad_reg <= rep.bad;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_out_row    = out_row_reg;
    assign m_row_sum    = out_sum_reg;
    assign m_saturated  = out_sat_reg;
    assign m_bad_column = out_bad_reg;

endmodule

`default_nettype wire

// File: sv/csrspmv_mac.sv
// multiply and saturating accumulate for one nonzero a cycle while adv is high, reports each finished row
// depends on csrspmv_pkg
`timescale 1ns / 1ps
`default_nettype none

module csrspmv_mac
    import csrspmv_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  adv,
    input  wire mac_in_t               nz_in,
    input  wire logic signed [Q_W-1:0] vec_elem,
    output row_rep_t                   rep
);

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // product stage
    logic                     p_valid_reg;
    logic                     p_bad_reg;
    logic                     p_last_reg;
    logic [ROW_W-1:0]         p_row_reg;
    logic signed [PROD_W-1:0] p_prod_reg;

    // accumulate stage
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     col_err_reg;
    row_rep_t                 rep_reg;

    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0]  term;
    logic signed [ACC_W:0]    sum_wide;
    logic signed [ACC_W-1:0]  acc_next;
    logic                     col_err_next;

    // 32x32 signed multiply, exact at 64 bits
    assign prod = nz_in.value * vec_elem;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else if (adv) begin
            p_valid_reg <= nz_in.valid;
        end
        if (adv) begin
            p_bad_reg  <= nz_in.bad;
            p_last_reg <= nz_in.last;
            p_row_reg  <= nz_in.row;
            // a bad column never uses the element, which may be unwritten
            p_prod_reg <= nz_in.bad ? '0 : prod;
        end
    end

    // arithmetic shift is floor division by 2^16
    assign term     = ACC_W'(p_prod_reg >>> FRAC_W);
    assign sum_wide = {acc_reg[ACC_W-1], acc_reg} + {term[ACC_W-1], term};

    always_comb begin
        if (p_bad_reg) begin
            acc_next = acc_reg;
        end else if (sum_wide[ACC_W] != sum_wide[ACC_W-1]) begin
            acc_next = sum_wide[ACC_W] ? ACC_MIN : ACC_MAX;
        end else begin
            acc_next = sum_wide[ACC_W-1:0];
        end
        col_err_next = col_err_reg | p_bad_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg       <= '0;
            col_err_reg   <= 1'b0;
            rep_reg.valid <= 1'b0;
        end else if (adv) begin
            rep_reg.valid <= p_valid_reg & p_last_reg;
            if (p_valid_reg) begin
                if (p_last_reg) begin
                    acc_reg     <= '0;
                    col_err_reg <= 1'b0;
                end else begin
                    acc_reg     <= acc_next;
                    col_err_reg <= col_err_next;
                end
            end
        end
        if (adv) begin
            rep_reg.bad <= col_err_next;
            rep_reg.row <= p_row_reg;
            rep_reg.sum <= acc_next;
        end
    end

    assign rep = rep_reg;

endmodule

`default_nettype wire
